/* rtl/core/mlla_pkg.sv */
// Shared types and constants for the multichannel loop level averager.
package mlla_pkg;

  // Fixed field widths
  localparam int CH_FIELD_W = 3;
  localparam int MV_W       = 12;
  localparam int CMA_W      = 11;
  localparam int LVL_W      = 16;
  localparam int FILLED_W   = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MV    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_MV    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd2;

  localparam logic [MV_W-1:0]  ZERO_MV_RST    = 12'd800;
  localparam logic [MV_W-1:0]  SPAN_MV_RST    = 12'd3200;
  localparam logic [LVL_W-1:0] FULL_SCALE_RST = 16'd3000;

  // Saturation limit of the loop current in hundredths of a mA
  localparam logic [CMA_W-1:0] CMA_MAX = 11'd2047;

  typedef struct packed {
    logic [CH_FIELD_W-1:0] channel;
    logic [MV_W-1:0]       sample_mv;
  } in_item_t;

  typedef struct packed {
    logic [CH_FIELD_W-1:0] out_channel;
    logic [CMA_W-1:0]      avg_centi_ma;
    logic [LVL_W-1:0]      level_tenth_cm;
    logic [FILLED_W-1:0]   filled;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic write;
    logic read;
    logic div_mean;
    logic mean_load;
    logic lvl_calc;
    logic div_lvl;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ch_ok;
    logic last_rd;
    logic div_done;
  } sts_t;

endpackage

/* rtl/core/mlla_div.sv */
// Restoring serial divider, one quotient bit per cycle.
module mlla_div #(
  parameter int DVD_W = 28,
  parameter int DVS_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] q_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   trial;
  logic             ge;
  logic [DVS_W-1:0] rem_nxt;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    shifted = {rem_r, q_r[DVD_W-1]};
    trial   = shifted - {1'b0, dvs_r};
    ge      = shifted >= {1'b0, dvs_r};
    rem_nxt = ge ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
  end

  // Control: count steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Data: quotient shifts in from the bottom as the dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

/* rtl/core/mlla_dpath.sv */
// Datapath: sample store, ring pointers, window sum, scaling and config registers.
module mlla_dpath #(
  parameter int CHANNELS    = 8,
  parameter int WINDOW      = 10,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mlla_pkg::cmd_t                     cmd,
  output mlla_pkg::sts_t                     sts,
  input  mlla_pkg::in_item_t                 in_data,
  input  logic                               cfg_we,
  input  logic [mlla_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mlla_pkg::CFG_DATA_W-1:0]    cfg_data,
  output mlla_pkg::out_item_t                out_data
);

  localparam int DEPTH  = CHANNELS * WINDOW;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int PROD_W = mlla_pkg::MV_W + mlla_pkg::LVL_W;
  localparam int DVS_W  = (CNT_W > mlla_pkg::MV_W) ? CNT_W : mlla_pkg::MV_W;
  localparam int DVD_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam int CMP_W  = 17;

  // Configuration registers
  logic [mlla_pkg::MV_W-1:0]  zero_r;
  logic [mlla_pkg::MV_W-1:0]  span_r;
  logic [mlla_pkg::LVL_W-1:0] fs_r;

  // Captured transaction
  logic [4:0]                       ch5;
  logic [CH_W-1:0]                  ch_idx_r;
  logic [mlla_pkg::CH_FIELD_W-1:0]  ch_r;
  logic [SAMPLE_BITS-1:0]           sample_r;

  // Ring pointers per channel
  logic [POS_W-1:0] pos_r  [CHANNELS];
  logic [CNT_W-1:0] fill_r [CHANNELS];
  logic [POS_W-1:0] pos_cur;
  logic [CNT_W-1:0] fill_cur;
  logic [POS_W-1:0] pos_nxt;
  logic [CNT_W-1:0] fill_nxt;

  // Sample store
  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]      wr_addr;
  logic [ADDR_W-1:0]      rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data_r;
  logic                   acc_en_r;

  // Sum walk
  logic [POS_W-1:0] idx_r;
  logic [CNT_W-1:0] n_r;
  logic [SUM_W-1:0] sum_r;

  // Scaling
  logic [SAMPLE_BITS-1:0]      mean_r;
  logic [CMP_W-1:0]            mean_ext;
  logic [CMP_W-1:0]            zero_ext;
  logic [CMP_W-1:0]            top_ext;
  logic [CMP_W-1:0]            diff;
  logic [PROD_W-1:0]           prod_nxt;
  logic [PROD_W-1:0]           prod_r;
  logic                        below_r;
  logic                        above_r;
  logic [SAMPLE_BITS-1:0]      half;
  logic [mlla_pkg::CMA_W-1:0]  cma_nxt;
  logic [mlla_pkg::CMA_W-1:0]  cma_r;
  logic [mlla_pkg::LVL_W-1:0]  level_nxt;
  logic [7:0]                  n_ext;
  mlla_pkg::out_item_t         out_r;

  // Divider
  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;
  logic [DVD_W-1:0] div_q;

  // Channel range check on the offered transaction
  assign ch5 = 5'(in_data.channel);

  always_comb begin
    sts.ch_ok    = ch5 < 5'(CHANNELS);
    sts.last_rd  = CNT_W'(idx_r) == (n_r - CNT_W'(1));
    sts.div_done = div_done;
  end

  // Write config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_r <= mlla_pkg::ZERO_MV_RST;
      span_r <= mlla_pkg::SPAN_MV_RST;
      fs_r   <= mlla_pkg::FULL_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mlla_pkg::CFG_ZERO_MV:    zero_r <= cfg_data[mlla_pkg::MV_W-1:0];
        mlla_pkg::CFG_SPAN_MV:    span_r <= cfg_data[mlla_pkg::MV_W-1:0];
        mlla_pkg::CFG_FULL_SCALE: fs_r   <= cfg_data[mlla_pkg::LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the offered transaction while idle and hold it while busy
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch_idx_r <= ch5[CH_W-1:0];
      ch_r     <= in_data.channel;
      sample_r <= SAMPLE_BITS'(in_data.sample_mv);
    end
  end

  // Advance ring pointer and fill count
  always_comb begin
    pos_cur  = pos_r[ch_idx_r];
    fill_cur = fill_r[ch_idx_r];
    pos_nxt  = (pos_cur == POS_W'(WINDOW - 1)) ? '0 : pos_cur + POS_W'(1);
    fill_nxt = (fill_cur < CNT_W'(WINDOW)) ? fill_cur + CNT_W'(1) : fill_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        pos_r[c]  <= '0;
        fill_r[c] <= '0;
      end
    end else if (cmd.write) begin
      pos_r[ch_idx_r]  <= pos_nxt;
      fill_r[ch_idx_r] <= fill_nxt;
    end
  end

  // Store addresses: channel row plus slot
  assign wr_addr = ADDR_W'(32'(ch_idx_r) * WINDOW + 32'(pos_cur));
  assign rd_addr = ADDR_W'(32'(ch_idx_r) * WINDOW + 32'(idx_r));

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[wr_addr] <= sample_r;
    end
    if (cmd.read) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Walk the window and accumulate one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= cmd.read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      n_r   <= fill_nxt;
      idx_r <= '0;
      sum_r <= '0;
    end else begin
      if (cmd.read) begin
        idx_r <= idx_r + POS_W'(1);
      end
      if (acc_en_r) begin
        sum_r <= sum_r + SUM_W'(rd_data_r);
      end
    end
  end

  // Share the divider between the mean and the level
  assign div_start = cmd.div_mean | cmd.div_lvl;
  assign div_dvd   = cmd.div_lvl ? DVD_W'(prod_r) : DVD_W'(sum_r);
  assign div_dvs   = cmd.div_lvl ? DVS_W'(span_r) : DVS_W'(n_r);

  mlla_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.mean_load) begin
      mean_r <= SAMPLE_BITS'(div_q);
    end
  end

  // Clamp tests, level product and loop current from the mean
  always_comb begin
    mean_ext = CMP_W'(mean_r);
    zero_ext = CMP_W'(zero_r);
    top_ext  = CMP_W'(zero_r) + CMP_W'(span_r);
    diff     = mean_ext - zero_ext;
    prod_nxt = diff[mlla_pkg::MV_W-1:0] * fs_r;
    half     = mean_r >> 1;
    cma_nxt  = (CMP_W'(half) > CMP_W'(mlla_pkg::CMA_MAX)) ?
               mlla_pkg::CMA_MAX : mlla_pkg::CMA_W'(half);
  end

  always_ff @(posedge clk) begin
    if (cmd.lvl_calc) begin
      below_r <= mean_ext <= zero_ext;
      above_r <= mean_ext >= top_ext;
      prod_r  <= prod_nxt;
      cma_r   <= cma_nxt;
    end
  end

  // Load the result register
  always_comb begin
    if (below_r) begin
      level_nxt = '0;
    end else if (above_r) begin
      level_nxt = fs_r;
    end else begin
      level_nxt = div_q[mlla_pkg::LVL_W-1:0];
    end
    n_ext = 8'(n_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.out_channel    <= ch_r;
      out_r.avg_centi_ma   <= cma_r;
      out_r.level_tenth_cm <= level_nxt;
      out_r.filled         <= n_ext[mlla_pkg::FILLED_W-1:0];
    end
  end

  assign out_data = out_r;

endmodule

/* rtl/core/mlla_ctrl.sv */
// Controller: sequences one transaction through the datapath and owns the handshakes.
module mlla_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  mlla_pkg::sts_t sts,
  output mlla_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_SUM,
    S_SUM_END,
    S_DIVM_GO,
    S_DIVM_WAIT,
    S_LEVEL,
    S_DIVL_GO,
    S_DIVL_WAIT,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.capture = 1'b1;
        // drop transactions for channels that are not present
        if (in_valid && sts.ch_ok) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.read = 1'b1;
        if (sts.last_rd) begin
          state_nxt = S_SUM_END;
        end
      end
      S_SUM_END: begin
        state_nxt = S_DIVM_GO;
      end
      S_DIVM_GO: begin
        cmd.div_mean = 1'b1;
        state_nxt    = S_DIVM_WAIT;
      end
      S_DIVM_WAIT: begin
        if (sts.div_done) begin
          cmd.mean_load = 1'b1;
          state_nxt     = S_LEVEL;
        end
      end
      S_LEVEL: begin
        cmd.lvl_calc = 1'b1;
        state_nxt    = S_DIVL_GO;
      end
      S_DIVL_GO: begin
        cmd.div_lvl = 1'b1;
        state_nxt   = S_DIVL_WAIT;
      end
      S_DIVL_WAIT: begin
        if (sts.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result valid: set on load, clear when taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule

/* rtl/core/multichannel_loop_level_averager.sv */
// Top level of the multichannel 4-20 mA loop level averager.
//
// Each input transaction carries a channel and a shunt reading in mV; the reading
// goes into that channel's ring of the last WINDOW readings, and one result
// transaction returns the window mean as loop current (hundredths of a mA) and as
// a clamped linear level (tenths of a cm), plus the number of readings used.
// Transactions for channels at or above CHANNELS are dropped with no result.
// The block works on one transaction at a time: after acceptance it stores the
// reading and sums the filled part of its ring, filled being the window count
// after the new reading; then the shared serial divider, DVD bits wide (28 at
// the default sizes), produces one quotient bit a cycle, first for the mean
// and then for the level. The sum walk reads one ring entry a cycle from the
// single-port sample store. The result loads only once the previous result is
// taken, so a stalled previous result holds off the load.
// The next transaction is taken once the result is loaded, while the result may
// still wait at the output. Ring pointers and fill counts clear at reset; the
// sample store needs no clearing pass.
module multichannel_loop_level_averager #(
  parameter int CHANNELS    = 8,
  parameter int WINDOW      = 10,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mlla_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mlla_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [mlla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlla_pkg::CFG_DATA_W-1:0] cfg_data
);

  mlla_pkg::cmd_t cmd;
  mlla_pkg::sts_t sts;

  mlla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mlla_dpath #(
    .CHANNELS    (CHANNELS),
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

/* rtl/core/mlla_checker.sv */
// Port-level checker for the loop level averager, bound to the top level.
module mlla_checker #(
  parameter int CHANNELS = 8,
  parameter int WINDOW   = 10
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input mlla_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input mlla_pkg::out_item_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed or dropped");

  // Busy after a transaction for a present channel
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (5'(in_data.channel) < 5'(CHANNELS)) |=> in_stall)
    else $error("block did not go busy after accepting a transaction");

  // Stay ready after a dropped transaction
  a_drop_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (5'(in_data.channel) >= 5'(CHANNELS)) |=> !in_stall)
    else $error("dropped transaction made the block busy");

  // Result fields stay in range
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (5'(out_data.out_channel) < 5'(CHANNELS)) &&
                  (out_data.filled != '0) &&
                  (8'(out_data.filled) <= 8'(WINDOW)))
    else $error("result channel or fill count out of range");

endmodule

bind multichannel_loop_level_averager mlla_checker #(
  .CHANNELS (CHANNELS),
  .WINDOW   (WINDOW)
) u_mlla_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* tb/multichannel_loop_level_averager_checker.sv */
// Checker for the loop level averager: predicts every result transaction and compares it.
`timescale 1ns / 1ps
module multichannel_loop_level_averager_checker #(
  parameter int CHANNELS = 8,
  parameter int WINDOW   = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  mlla_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  mlla_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [mlla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlla_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending_count
);

  // Shadow copy of the per-channel reading rings and the level settings
  logic [mlla_pkg::MV_W-1:0]     ring     [CHANNELS][WINDOW];
  logic [mlla_pkg::FILLED_W-1:0] wr_slot  [CHANNELS];
  logic [mlla_pkg::FILLED_W-1:0] fill_cnt [CHANNELS];
  logic [mlla_pkg::MV_W-1:0]     zero_mv;
  logic [mlla_pkg::MV_W-1:0]     span_mv;
  logic [mlla_pkg::LVL_W-1:0]    full_scale;

  mlla_pkg::out_item_t expected_results [$];
  mlla_pkg::out_item_t oldest;
  int                  errs;

  // Clamped linear level of a window mean; a zero span never divides
  function automatic logic [mlla_pkg::LVL_W-1:0] level_of_mean(int unsigned mean);
    int unsigned top_mv;
    top_mv = 32'(zero_mv) + 32'(span_mv);
    if (mean <= zero_mv) return '0;
    if (mean >= top_mv) return full_scale;
    return mlla_pkg::LVL_W'((64'(mean - zero_mv) * 64'(full_scale)) / 64'(span_mv));
  endfunction

  // Store the reading in its ring, then average the filled part of the window
  function automatic mlla_pkg::out_item_t predict_reading(mlla_pkg::in_item_t it);
    mlla_pkg::out_item_t res;
    int unsigned         ch;
    int unsigned         sum;
    int unsigned         mean;
    int unsigned         n;
    ch = it.channel;
    ring[ch][wr_slot[ch]] = it.sample_mv;
    if (wr_slot[ch] == WINDOW - 1) wr_slot[ch] = '0;
    else wr_slot[ch] = wr_slot[ch] + 1'b1;
    if (fill_cnt[ch] < WINDOW) fill_cnt[ch] = fill_cnt[ch] + 1'b1;
    n   = fill_cnt[ch];
    sum = 0;
    for (int i = 0; i < n; i++) sum += ring[ch][i];
    mean = sum / n;
    res.out_channel    = it.channel;
    res.avg_centi_ma   = (mean / 2 > mlla_pkg::CMA_MAX) ?
                         mlla_pkg::CMA_MAX : mlla_pkg::CMA_W'(mean / 2);
    res.level_tenth_cm = level_of_mean(mean);
    res.filled         = mlla_pkg::FILLED_W'(n);
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (wr_slot[c]) begin
        wr_slot[c]  = '0;
        fill_cnt[c] = '0;
      end
      zero_mv    = mlla_pkg::ZERO_MV_RST;
      span_mv    = mlla_pkg::SPAN_MV_RST;
      full_scale = mlla_pkg::FULL_SCALE_RST;
      expected_results.delete();
      errs = 0;
    end else begin
      // Compare a result transaction with the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction for channel %0d", out_data.out_channel);
          errs++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("out_channel", oldest.out_channel, out_data.out_channel);
          check_field("avg_centi_ma", oldest.avg_centi_ma, out_data.avg_centi_ma);
          check_field("level_tenth_cm", oldest.level_tenth_cm, out_data.level_tenth_cm);
          check_field("filled", oldest.filled, out_data.filled);
        end
      end
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          mlla_pkg::CFG_ZERO_MV:    zero_mv    = cfg_data[mlla_pkg::MV_W-1:0];
          mlla_pkg::CFG_SPAN_MV:    span_mv    = cfg_data[mlla_pkg::MV_W-1:0];
          mlla_pkg::CFG_FULL_SCALE: full_scale = cfg_data[mlla_pkg::LVL_W-1:0];
          default: ;
        endcase
      end
      // Predict each accepted reading; absent channels give no result
      if (in_valid && !in_stall && in_data.channel < CHANNELS) begin
        expected_results.push_back(predict_reading(in_data));
      end
    end
    fail_count    <= errs;
    pending_count <= expected_results.size();
  end

endmodule

/* tb/multichannel_loop_level_averager_tb.sv */
// Testbench top for the loop level averager: stimulus, result stalls and verdict.
`timescale 1ns / 1ps
module multichannel_loop_level_averager_tb;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_CYCLES = 80;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  mlla_pkg::in_item_t              in_data;
  logic                            out_valid;
  logic                            out_stall;
  mlla_pkg::out_item_t             out_data;
  logic                            cfg_we;
  logic [mlla_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mlla_pkg::CFG_DATA_W-1:0] cfg_data;

  int          fail_count;
  int          pending_count;
  int          cycle_count;
  bit          no_idle;
  int unsigned cur_zero;
  int unsigned cur_span;

  multichannel_loop_level_averager u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  multichannel_loop_level_averager_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multichannel_loop_level_averager_tb failed");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Stall the result channel in random bursts
  initial begin : result_stall
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      n = idle_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  end

  // Offer one reading and hold it until accepted; valid stays high afterwards
  task automatic send_reading(mlla_pkg::in_item_t it);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Write all three level registers while the block is idle
  task automatic write_config(int unsigned zero, int unsigned span, int unsigned fs);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= mlla_pkg::CFG_ZERO_MV;
    cfg_data  <= mlla_pkg::CFG_DATA_W'(zero);
    @(posedge clk);
    cfg_index <= mlla_pkg::CFG_SPAN_MV;
    cfg_data  <= mlla_pkg::CFG_DATA_W'(span);
    @(posedge clk);
    cfg_index <= mlla_pkg::CFG_FULL_SCALE;
    cfg_data  <= mlla_pkg::CFG_DATA_W'(fs);
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_zero = zero;
    cur_span = span;
  endtask

  // Random reading, biased toward the rails and the two level breakpoints
  function automatic mlla_pkg::in_item_t random_reading();
    mlla_pkg::in_item_t it;
    int                 mv;
    int                 pick;
    it.channel = $urandom_range(0, 7);
    pick = $urandom_range(0, 9);
    case (pick)
      0:       mv = $urandom_range(0, 1) ? 4095 : 0;
      1, 2:    mv = int'(cur_zero) + int'($urandom_range(0, 4)) - 2;
      3, 4:    mv = int'(cur_zero + cur_span) + int'($urandom_range(0, 4)) - 2;
      default: mv = $urandom_range(0, 4095);
    endcase
    it.sample_mv = (mv < 0) ? '0 : (mv > 4095) ? '1 : mlla_pkg::MV_W'(mv);
    return it;
  endfunction

  task automatic run_random(int count);
    mlla_pkg::in_item_t it;
    int                 sent;
    int                 run;
    sent = 0;
    while (sent < count) begin
      it = random_reading();
      // repeat one reading on one channel long enough to fill its window
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 12) : 1;
      repeat (run) begin
        send_reading(it);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= mlla_pkg::CFG_ZERO_MV;
    cfg_data  <= '0;
    no_idle   = 1'b0;
    cur_zero  = mlla_pkg::ZERO_MV_RST;
    cur_span  = mlla_pkg::SPAN_MV_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed readings at reset settings: rails, breakpoints, window wrap
    send_reading(mlla_pkg::in_item_t'{3'd0, 12'd0});
    send_reading(mlla_pkg::in_item_t'{3'd7, 12'd4095});
    send_reading(mlla_pkg::in_item_t'{3'd1, 12'd800});
    send_reading(mlla_pkg::in_item_t'{3'd2, 12'd4000});
    send_reading(mlla_pkg::in_item_t'{3'd3, 12'd3999});
    send_reading(mlla_pkg::in_item_t'{3'd4, 12'd801});
    send_reading(mlla_pkg::in_item_t'{3'd5, 12'd2400});
    send_reading(mlla_pkg::in_item_t'{3'd6, 12'd1});
    repeat (11) send_reading(mlla_pkg::in_item_t'{3'd0, 12'd4095});
    send_reading(mlla_pkg::in_item_t'{3'd6, 12'd4094});

    // Widest span with the largest full scale
    write_config(0, 4095, 65535);
    run_random(200);

    // Zero point at the top: level never leaves zero
    write_config(4095, 4095, 0);
    run_random(120);

    // Zero span: level is a step at the zero point
    write_config(1000, 0, 12345);
    run_random(150);

    // One millivolt span
    write_config(0, 1, 65535);
    run_random(150);

    // Back to reset values at full rate, with a pause for all results midway
    write_config(mlla_pkg::ZERO_MV_RST, mlla_pkg::SPAN_MV_RST, mlla_pkg::FULL_SCALE_RST);
    no_idle = 1'b1;
    run_random(100);
    drain();
    run_random(100);
    no_idle = 1'b0;

    // Random settings
    repeat (4) begin
      write_config($urandom_range(0, 4095), $urandom_range(1, 4095), $urandom_range(0, 65535));
      run_random(180);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("multichannel_loop_level_averager_tb passed");
    end else begin
      $display("multichannel_loop_level_averager_tb failed");
    end
    $finish;
  end

endmodule
